// File: rtl/abo_pkg.sv
// Shared types and constants for the animated bitmap overlay.
// Used by animated_bitmap_overlay_unit and its testbench; depends on nothing.
package abo_pkg;

    // Default geometry of the logo artwork.
    localparam int ART_WIDTH_DEF   = 128;
    localparam int ART_HEIGHT_DEF  = 32;
    localparam int LEFT_MARGIN_DEF = 4;

    // Animation timing in frames.
    localparam int ENTER_FRAMES = 60;
    localparam int HOLD_FRAMES  = 180;

    // Art store geometry.
    localparam int STORE_DEPTH  = 1024;
    localparam int STORE_ADDR_W = 10;
    localparam int ART_BYTE_W   = 8;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BORDER_LINES      = 3'd0,
        CFG_ACTIVE_LINES      = 3'd1,
        CFG_LAST_VIRTUAL_LINE = 3'd2,
        CFG_COLOUR_ONE        = 3'd3,
        CFG_COLOUR_TWO        = 3'd4,
        CFG_COLOUR_THREE      = 3'd5,
        CFG_HIDE_ALLOWED      = 3'd6
    } t_cfg_index;

    typedef enum logic [1:0] {
        KIND_LINE_BEGIN = 2'd0,
        KIND_PIXEL      = 2'd1,
        KIND_LOAD_ART   = 2'd2,
        KIND_RESTART    = 2'd3
    } t_kind;

    // Two-bit art indices.
    localparam logic [1:0] IDX_CLEAR = 2'd0;
    localparam logic [1:0] IDX_ONE   = 2'd1;
    localparam logic [1:0] IDX_TWO   = 2'd2;
    localparam logic [1:0] IDX_THREE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] line;
        logic [31:0] frame_number;
        logic [9:0]  column;
        logic [15:0] background;
        logic [9:0]  art_address;
        logic [7:0]  art_byte;
    } t_in_req;

    typedef struct packed {
        logic [9:0]  out_column;
        logic [15:0] out_pixel;
        logic        covered;
    } t_out_res;

endpackage

// File: rtl/abo_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Standalone; used for the art store of the bitmap overlay.
module abo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // The read data holds while no read is issued.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/animated_bitmap_overlay_unit.sv
// A pixel's result passes through read stage s1 and then the output register.
// Takes one request per cycle unless stalled; line, load and restart give no result.
// The art store is read once per in-span pixel request through one RAM read port.
// Reset (i_rst_n low, synchronous) clears config/row registers and valids, sets the
// band offset to its start value; the art store is not cleared and must be loaded.
// Top level of the bitmap overlay; depends on abo_pkg and abo_ram.
module animated_bitmap_overlay_unit
    import abo_pkg::*;
#(
    parameter int ART_WIDTH   = ART_WIDTH_DEF,
    parameter int ART_HEIGHT  = ART_HEIGHT_DEF,
    parameter int LEFT_MARGIN = LEFT_MARGIN_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Request channel.
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_req                i_in_data,
    // Result channel.
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_res               o_out_data
);

    // Width of the latched band row: enough for 0 .. ART_HEIGHT-1.
    localparam int ROW_W = (ART_HEIGHT > 1) ? $clog2(ART_HEIGHT) : 1;
    // Band offset after reset and after a restart request.
    localparam logic [15:0] START_OFFSET = 16'(ENTER_FRAMES + ART_HEIGHT + 2);
    // Column span of the artwork, compared at 11 bits so the end never wraps.
    localparam logic [10:0] SPAN_FIRST = 11'(LEFT_MARGIN);
    localparam logic [10:0] SPAN_END   = 11'(LEFT_MARGIN + ART_WIDTH);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [9:0]  r_border_lines;
    logic [9:0]  r_active_lines;
    logic [9:0]  r_last_virtual_line;
    logic [15:0] r_colour_one;
    logic [15:0] r_colour_two;
    logic [15:0] r_colour_three;
    logic        r_hide_allowed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_border_lines      <= '0;
            r_active_lines      <= '0;
            r_last_virtual_line <= '0;
            r_colour_one        <= '0;
            r_colour_two        <= '0;
            r_colour_three      <= '0;
            r_hide_allowed      <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_BORDER_LINES:      r_border_lines      <= i_cfg_data[9:0];
                CFG_ACTIVE_LINES:      r_active_lines      <= i_cfg_data[9:0];
                CFG_LAST_VIRTUAL_LINE: r_last_virtual_line <= i_cfg_data[9:0];
                CFG_COLOUR_ONE:        r_colour_one        <= i_cfg_data;
                CFG_COLOUR_TWO:        r_colour_two        <= i_cfg_data;
                CFG_COLOUR_THREE:      r_colour_three      <= i_cfg_data;
                CFG_HIDE_ALLOWED:      r_hide_allowed      <= i_cfg_data[0];
                default: begin
                    // Writes beyond the register list are ignored.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. Pixel requests pass through a read stage (s1, waiting on
    // the art RAM) and then the output register. The output register loads
    // whenever it is empty or being taken, so s1 only blocks new requests
    // when it holds a pixel and the output side is stalled with a result.
    // ------------------------------------------------------------------
    logic w_in_accept;
    logic w_out_load;
    logic r_s1_valid;
    logic r_out_valid;

    assign w_out_load  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !w_out_load;
    assign w_in_accept = i_in_valid && !o_in_stall;

    logic w_is_line;
    logic w_is_pixel;
    logic w_is_load;
    logic w_is_restart;

    assign w_is_line    = (t_kind'(i_in_data.kind) == KIND_LINE_BEGIN);
    assign w_is_pixel   = (t_kind'(i_in_data.kind) == KIND_PIXEL);
    assign w_is_load    = (t_kind'(i_in_data.kind) == KIND_LOAD_ART);
    assign w_is_restart = (t_kind'(i_in_data.kind) == KIND_RESTART);

    // ------------------------------------------------------------------
    // Band animation and row latch. On line 0 the offset slides down while
    // the logo enters and, if hiding is allowed, up after the hold period.
    // The row for the line is taken against the already updated offset.
    // ------------------------------------------------------------------
    logic [15:0]      r_band_offset;
    logic [ROW_W-1:0] r_band_row;
    logic             r_row_valid;

    logic [15:0] w_next_offset;
    logic [15:0] w_row_full;
    logic        w_row_ok;

    always_comb begin
        w_next_offset = r_band_offset;
        if (i_in_data.line == 16'd0) begin
            if (i_in_data.frame_number < 32'(ENTER_FRAMES)) begin
                w_next_offset = r_band_offset - 16'd1;
            end else if (r_hide_allowed &&
                         i_in_data.frame_number > 32'(ENTER_FRAMES + HOLD_FRAMES)) begin
                w_next_offset = r_band_offset + 16'd1;
            end
        end
        w_row_full = i_in_data.line - 16'(r_border_lines) - 16'(r_active_lines)
                   - w_next_offset;
        w_row_ok   = (i_in_data.line <= 16'(r_last_virtual_line)) &&
                     (w_row_full < 16'(ART_HEIGHT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_offset <= START_OFFSET;
            r_band_row    <= '0;
            r_row_valid   <= 1'b0;
        end else if (w_in_accept) begin
            if (w_is_line) begin
                r_band_offset <= w_next_offset;
                r_row_valid   <= w_row_ok;
                r_band_row    <= w_row_ok ? w_row_full[ROW_W-1:0] : '0;
            end else if (w_is_restart) begin
                r_band_offset <= START_OFFSET;
            end
        end
    end

    // ------------------------------------------------------------------
    // Art address for a pixel: row * ART_WIDTH / 4 + (column - margin) / 4,
    // wrapped to the store. The product is a multiply by a constant.
    // ------------------------------------------------------------------
    logic                    w_in_span;
    logic [9:0]              w_x;
    logic [31:0]             w_row_base;
    logic [STORE_ADDR_W-1:0] w_art_raddr;

    always_comb begin
        w_in_span   = r_row_valid &&
                      ({1'b0, i_in_data.column} >= SPAN_FIRST) &&
                      ({1'b0, i_in_data.column} <  SPAN_END);
        w_x         = i_in_data.column - 10'(LEFT_MARGIN);
        w_row_base  = 32'(r_band_row) * 32'(ART_WIDTH);
        w_art_raddr = STORE_ADDR_W'((w_row_base >> 2) + 32'(w_x >> 2));
    end

    // The RAM read is issued only for an in-span pixel, so the read data
    // holds while s1 waits on a stalled output. A load accepted after the
    // pixel writes a later cycle and cannot disturb the held data.
    logic                  w_ram_we;
    logic                  w_ram_re;
    logic [ART_BYTE_W-1:0] w_ram_rdata;

    assign w_ram_we = w_in_accept && w_is_load;
    assign w_ram_re = w_in_accept && w_is_pixel && w_in_span;

    abo_ram #(
        .WIDTH (ART_BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_art_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_in_data.art_address),
        .i_wdata (i_in_data.art_byte),
        .i_re    (w_ram_re),
        .i_raddr (w_art_raddr),
        .o_rdata (w_ram_rdata)
    );

    // ------------------------------------------------------------------
    // Read stage s1: the pixel's column, background and pair position.
    // ------------------------------------------------------------------
    logic [9:0]  r_s1_column;
    logic [15:0] r_s1_background;
    logic        r_s1_in_span;
    logic [1:0]  r_s1_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_accept && w_is_pixel) begin
            r_s1_valid <= 1'b1;
        end else if (w_out_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept && w_is_pixel) begin
            r_s1_column     <= i_in_data.column;
            r_s1_background <= i_in_data.background;
            r_s1_in_span    <= w_in_span;
            r_s1_pair       <= w_x[1:0];
        end
    end

    // Pick the pair, leftmost pixel in the top bits, then the palette.
    logic [1:0]  w_index;
    logic        w_covered;
    logic [15:0] w_pixel;

    always_comb begin
        case (r_s1_pair)
            2'd0:    w_index = w_ram_rdata[7:6];
            2'd1:    w_index = w_ram_rdata[5:4];
            2'd2:    w_index = w_ram_rdata[3:2];
            default: w_index = w_ram_rdata[1:0];
        endcase
        w_covered = r_s1_in_span && (w_index != IDX_CLEAR);
        w_pixel   = r_s1_background;
        if (w_covered) begin
            case (w_index)
                IDX_ONE:   w_pixel = r_colour_one;
                IDX_TWO:   w_pixel = r_colour_two;
                IDX_THREE: w_pixel = r_colour_three;
                default:   w_pixel = r_s1_background;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    t_out_res r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load && r_s1_valid) begin
            r_out.out_column <= r_s1_column;
            r_out.out_pixel  <= w_pixel;
            r_out.covered    <= w_covered;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid))
        else $error("request side stalled without a full pipeline");

    a_pixel_enters_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && w_is_pixel) |=> r_s1_valid)
        else $error("accepted pixel request did not reach the read stage");

    a_s1_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_out_load && !(w_in_accept && w_is_pixel)) |=>
        (!r_s1_valid && r_out_valid))
        else $error("read stage did not hand its pixel to the output");

    a_covered_is_palette: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.covered) |->
        (o_out_data.out_pixel == r_colour_one || o_out_data.out_pixel == r_colour_two ||
         o_out_data.out_pixel == r_colour_three))
        else $error("covered pixel is not a palette colour");

    a_row_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_row_valid |-> (r_band_row == '0))
        else $error("band row kept while the row is not valid");

endmodule

// File: verif/tb_animated_bitmap_overlay_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for animated_bitmap_overlay_unit: directed requests, then random
// scan-line traffic, checked against typed-in results or the predictor. Depends on abo_pkg.
module tb_animated_bitmap_overlay_unit;
    import abo_pkg::*;

    // Band offset after reset and after a restart request.
    localparam logic [15:0] BAND_START = 16'(ENTER_FRAMES + ART_HEIGHT_DEF + 2);
    // Four 2-bit indices are packed into each art byte.
    localparam int PIX_PER_BYTE = 4;
    localparam int LIMIT        = 200000;
    localparam int LONG_HOLD    = 64;
    localparam int SETTLE       = 4;

    typedef enum {
        MIX_NONE,
        MIX_SENDER,
        MIX_RECEIVER,
        MIX_BOTH
    } t_idle_mix;

    // One row of the directed part. Where has_want is set the result is typed in.
    typedef struct {
        t_in_req  req;
        bit       has_want;
        t_out_res want;
    } t_directed_row;

    // One register setting of the block together with the idling used under it.
    typedef struct {
        logic [9:0]  border;
        logic [9:0]  active;
        logic [9:0]  last_line;
        logic [15:0] colour1;
        logic [15:0] colour2;
        logic [15:0] colour3;
        logic        hide;
        t_idle_mix   mix;
    } t_setting;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_BORDER_LINES;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    t_in_req                in_req = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_out_res               out_res;

    // Predictor copy of the configuration registers.
    logic [9:0]  cfg_border = '0;
    logic [9:0]  cfg_active = '0;
    logic [9:0]  cfg_last_line = '0;
    logic [15:0] cfg_colour1 = '0;
    logic [15:0] cfg_colour2 = '0;
    logic [15:0] cfg_colour3 = '0;
    logic        cfg_hide = 1'b0;

    // Predictor copy of the overlay state.
    logic [15:0] band_offset = BAND_START;
    logic [4:0]  band_row = '0;
    logic        row_valid = 1'b0;
    logic [7:0]  art_mem [STORE_DEPTH];
    // Marks the art bytes that have been loaded since reset.
    bit          art_loaded [STORE_DEPTH];

    // Pixel results the block still owes, oldest first.
    t_out_res    pixels_due[$];

    t_idle_mix   idle_mix = MIX_NONE;
    bit          hold_request = 1'b0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          requests_sent = 0;

    animated_bitmap_overlay_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_res)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs or drops a result.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Applies one register write to the predictor's copy of the configuration.
    function automatic void model_register(input t_cfg_index idx, input logic [15:0] value);
        case (idx)
            CFG_BORDER_LINES:      cfg_border = value[9:0];
            CFG_ACTIVE_LINES:      cfg_active = value[9:0];
            CFG_LAST_VIRTUAL_LINE: cfg_last_line = value[9:0];
            CFG_COLOUR_ONE:        cfg_colour1 = value;
            CFG_COLOUR_TWO:        cfg_colour2 = value;
            CFG_COLOUR_THREE:      cfg_colour3 = value;
            CFG_HIDE_ALLOWED:      cfg_hide = value[0];
            default: ;
        endcase
    endfunction

    // Advances the overlay state by one accepted request. Returns 1 when the request is a
    // pixel, with the pixel the block must return in res.
    function automatic bit overlay_step(input t_in_req r, output t_out_res res);
        logic [15:0] row_pos;
        logic [1:0]  idx;
        int          x;
        int          addr;
        res = '0;
        case (t_kind'(r.kind))
            KIND_LINE_BEGIN: begin
                // Only line 0 moves the band: in on entry, out past the hold if hide is set.
                if (r.line == 16'd0) begin
                    if (r.frame_number < ENTER_FRAMES)
                        band_offset = band_offset - 16'd1;
                    else if (cfg_hide && r.frame_number > ENTER_FRAMES + HOLD_FRAMES)
                        band_offset = band_offset + 16'd1;
                end
                row_pos = r.line - 16'(cfg_border) - 16'(cfg_active) - band_offset;
                row_valid = (r.line <= 16'(cfg_last_line)) && (row_pos < ART_HEIGHT_DEF);
                band_row = row_valid ? row_pos[4:0] : 5'd0;
                return 1'b0;
            end
            KIND_LOAD_ART: begin
                art_mem[r.art_address] = r.art_byte;
                art_loaded[r.art_address] = 1'b1;
                return 1'b0;
            end
            KIND_RESTART: begin
                band_offset = BAND_START;
                return 1'b0;
            end
            default: begin
                res.out_column = r.column;
                res.out_pixel = r.background;
                res.covered = 1'b0;
                if (row_valid && r.column >= LEFT_MARGIN_DEF &&
                        r.column < LEFT_MARGIN_DEF + ART_WIDTH_DEF) begin
                    x = int'(r.column) - LEFT_MARGIN_DEF;
                    addr = (int'(band_row) * ART_WIDTH_DEF / PIX_PER_BYTE + x / PIX_PER_BYTE)
                        % STORE_DEPTH;
                    // The leftmost pixel of a byte sits in its top two bits.
                    idx = 2'(art_mem[addr] >> (6 - 2 * (x % PIX_PER_BYTE)));
                    case (idx)
                        IDX_ONE:   res.out_pixel = cfg_colour1;
                        IDX_TWO:   res.out_pixel = cfg_colour2;
                        IDX_THREE: res.out_pixel = cfg_colour3;
                        default: ;
                    endcase
                    res.covered = (idx != IDX_CLEAR);
                end
                return 1'b1;
            end
        endcase
    endfunction

    // Store address a request reads under the current band row, or -1 if it reads none.
    function automatic int pixel_read_address(input t_in_req r);
        int x;
        x = int'(r.column) - LEFT_MARGIN_DEF;
        if (t_kind'(r.kind) != KIND_PIXEL || !row_valid || r.column < LEFT_MARGIN_DEF ||
                r.column >= LEFT_MARGIN_DEF + ART_WIDTH_DEF)
            return -1;
        return (int'(band_row) * ART_WIDTH_DEF / PIX_PER_BYTE + x / PIX_PER_BYTE) % STORE_DEPTH;
    endfunction

    function automatic bit sender_rests();
        case (idle_mix)
            MIX_SENDER: return $urandom_range(0, 99) < 66;
            MIX_BOTH:   return $urandom_range(0, 99) < 17;
            default:    return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_rests();
        case (idle_mix)
            MIX_RECEIVER: return $urandom_range(0, 99) < 66;
            MIX_BOTH:     return $urandom_range(0, 99) < 17;
            default:      return 1'b0;
        endcase
    endfunction

    // A request with every field random; callers then pin the fields that matter.
    function automatic t_in_req noise_request();
        t_in_req r;
        r.kind = 2'($urandom_range(0, 3));
        r.line = 16'($urandom_range(0, 65535));
        r.frame_number = $urandom();
        r.column = 10'($urandom_range(0, 1023));
        r.background = 16'($urandom_range(0, 65535));
        r.art_address = 10'($urandom_range(0, 1023));
        r.art_byte = 8'($urandom_range(0, 255));
        return r;
    endfunction

    // Offers one request and holds it until the block takes it. Called and left at a
    // falling edge; valid stays high on return so back-to-back requests leave no gap.
    task automatic offer_request(input t_in_req r, input bit use_want, input t_out_res want);
        t_out_res predicted;
        while (sender_rests()) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req <= r;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        // Accepted at this edge: move the predictor on and note the owed pixel, if any.
        requests_sent++;
        if (overlay_step(r, predicted))
            pixels_due.push_back(use_want ? want : predicted);
        @(negedge clk);
    endtask

    // The art store is undefined until written, so a pixel that would read a byte never
    // loaded is preceded by a load of that byte.
    task automatic push_request(input t_in_req r, input bit use_want, input t_out_res want);
        t_in_req fill;
        int      addr;
        addr = pixel_read_address(r);
        if (addr >= 0 && !art_loaded[addr]) begin
            fill = noise_request();
            fill.kind = KIND_LOAD_ART;
            fill.art_address = 10'(addr);
            offer_request(fill, 1'b0, '0);
        end
        offer_request(r, use_want, want);
    endtask

    // Stops offering and waits until every owed pixel is back and the pipeline is empty.
    task automatic drain();
        in_valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        model_register(idx, value);
        @(negedge clk);
    endtask

    // Writes all seven registers; the block must be idle when this is called.
    task automatic apply_setting(input t_setting s);
        write_reg(CFG_BORDER_LINES, 16'(s.border));
        write_reg(CFG_ACTIVE_LINES, 16'(s.active));
        write_reg(CFG_LAST_VIRTUAL_LINE, 16'(s.last_line));
        write_reg(CFG_COLOUR_ONE, s.colour1);
        write_reg(CFG_COLOUR_TWO, s.colour2);
        write_reg(CFG_COLOUR_THREE, s.colour3);
        write_reg(CFG_HIDE_ALLOWED, 16'(s.hide));
        cfg_we <= 1'b0;
        idle_mix = s.mix;
    endtask

    function automatic t_setting make_setting(input int border, input int active,
            input int last_line, input int c1, input int c2, input int c3, input bit hide,
            input t_idle_mix mix);
        t_setting s;
        s.border = 10'(border);
        s.active = 10'(active);
        s.last_line = 10'(last_line);
        s.colour1 = 16'(c1);
        s.colour2 = 16'(c2);
        s.colour3 = 16'(c3);
        s.hide = hide;
        s.mix = mix;
        return s;
    endfunction

    // Builds a directed row. For a line begin a and b are line and frame, for a pixel the
    // column and background, for a load the address and byte.
    function automatic t_directed_row make_row(input t_kind k, input int a, input int b,
            input bit has_want, input int want_pixel, input bit want_covered);
        t_directed_row d;
        d.req = '0;
        d.req.kind = k;
        case (k)
            KIND_LINE_BEGIN: begin
                d.req.line = 16'(a);
                d.req.frame_number = 32'(b);
            end
            KIND_PIXEL: begin
                d.req.column = 10'(a);
                d.req.background = 16'(b);
            end
            KIND_LOAD_ART: begin
                d.req.art_address = 10'(a);
                d.req.art_byte = 8'(b);
            end
            default: ;
        endcase
        d.has_want = has_want;
        d.want.out_column = 10'(a);
        d.want.out_pixel = 16'(want_pixel);
        d.want.covered = want_covered;
        return d;
    endfunction

    // Random scan-line traffic. Most of it is a line begin aimed into the band followed by
    // a run of pixels across the art span; the rest moves the animation, reloads art,
    // restarts, or is plain noise.
    task automatic random_traffic(input int budget);
        t_in_req     r;
        logic [15:0] aim;
        int          first;
        int          pick;
        int          run;
        int          col;
        first = requests_sent;
        while (requests_sent - first < budget) begin
            pick = $urandom_range(0, 99);
            r = noise_request();
            if (pick < 60) begin
                // Rows 0..31 lie in the band; a few rows just past it are aimed at as well.
                aim = 16'(cfg_border) + 16'(cfg_active) + band_offset
                    + 16'($urandom_range(0, ART_HEIGHT_DEF + 3));
                r.kind = KIND_LINE_BEGIN;
                r.line = aim;
                push_request(r, 1'b0, '0);
                run = $urandom_range(2, 14);
                col = $urandom_range(0, LEFT_MARGIN_DEF + ART_WIDTH_DEF + 4);
                repeat (run) begin
                    r = noise_request();
                    r.kind = KIND_PIXEL;
                    r.column = 10'(col);
                    push_request(r, 1'b0, '0);
                    col++;
                end
            end else if (pick < 72) begin
                // Line 0 drives the animation; pick a frame from each part of it.
                r.kind = KIND_LINE_BEGIN;
                r.line = 16'd0;
                case ($urandom_range(0, 3))
                    0: r.frame_number = $urandom_range(0, ENTER_FRAMES - 1);
                    1: r.frame_number = $urandom_range(ENTER_FRAMES, ENTER_FRAMES + HOLD_FRAMES);
                    2: r.frame_number = $urandom_range(ENTER_FRAMES + HOLD_FRAMES + 1, 4000);
                    default: r.frame_number = $urandom();
                endcase
                push_request(r, 1'b0, '0);
            end else if (pick < 80) begin
                r.kind = KIND_LOAD_ART;
                push_request(r, 1'b0, '0);
            end else if (pick < 84) begin
                r.kind = KIND_RESTART;
                push_request(r, 1'b0, '0);
            end else begin
                push_request(r, 1'b0, '0);
            end
        end
    endtask

    // Result side: stalls as the current idling mix asks, or for one long stretch on
    // request, which backs the pipeline up until the block stalls its input.
    initial begin : receiver_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= receiver_rests();
            end
        end
    end

    // Every result taken by the receiver is compared with the oldest owed pixel.
    always @(posedge clk) begin
        t_out_res owed;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (pixels_due.size() == 0) begin
                report_mismatch("result with nothing owed, column", int'(out_res.out_column), 0);
            end else begin
                owed = pixels_due.pop_front();
                if (out_res.out_column !== owed.out_column)
                    report_mismatch("out_column", int'(out_res.out_column),
                        int'(owed.out_column));
                if (out_res.out_pixel !== owed.out_pixel)
                    report_mismatch("out_pixel", int'(out_res.out_pixel), int'(owed.out_pixel));
                if (out_res.covered !== owed.covered)
                    report_mismatch("covered", int'(out_res.covered), int'(owed.covered));
            end
        end
    end

    initial begin : stimulus
        t_directed_row directed[$];
        t_setting      settings[$];

        foreach (art_mem[a])
            art_mem[a] = '0;

        // Synchronous reset held from the start, released at a falling edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed setting: the band starts at line 94; lines up to 1023 are all virtual.
        // Colour two is zero so that a covered pixel can still read as zero.
        apply_setting(make_setting(0, 0, 1023, 16'hFFFF, 16'h0000, 16'h8421, 1'b1, MIX_NONE));

        // No line has begun since reset, so the row is invalid and pixels pass through.
        directed.push_back(make_row(KIND_PIXEL, 0, 16'h0000, 1'b1, 16'h0000, 1'b0));
        directed.push_back(make_row(KIND_PIXEL, 1023, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0));
        // Top-left byte holds indices 0,1,2,3; bottom-right byte holds 3,2,1,0.
        directed.push_back(make_row(KIND_LOAD_ART, 0, 8'h1B, 1'b0, 0, 1'b0));
        directed.push_back(make_row(KIND_LOAD_ART, 1023, 8'hE4, 1'b0, 0, 1'b0));
        // First band row: left of the span, transparent, each colour, right of the span.
        directed.push_back(make_row(KIND_LINE_BEGIN, 94, 100, 1'b0, 0, 1'b0));
        directed.push_back(make_row(KIND_PIXEL, 3, 16'hABCD, 1'b1, 16'hABCD, 1'b0));
        directed.push_back(make_row(KIND_PIXEL, 4, 16'h5555, 1'b1, 16'h5555, 1'b0));
        directed.push_back(make_row(KIND_PIXEL, 5, 16'h1234, 1'b1, 16'hFFFF, 1'b1));
        directed.push_back(make_row(KIND_PIXEL, 6, 16'h1234, 1'b1, 16'h0000, 1'b1));
        directed.push_back(make_row(KIND_PIXEL, 7, 16'h1234, 1'b1, 16'h8421, 1'b1));
        directed.push_back(make_row(KIND_PIXEL, 132, 16'h0F0F, 1'b1, 16'h0F0F, 1'b0));
        // Last band row and the line just below the band.
        directed.push_back(make_row(KIND_LINE_BEGIN, 125, 7, 1'b0, 0, 1'b0));
        directed.push_back(make_row(KIND_PIXEL, 128, 16'h0001, 1'b1, 16'h8421, 1'b1));
        directed.push_back(make_row(KIND_PIXEL, 131, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0));
        directed.push_back(make_row(KIND_LINE_BEGIN, 126, 7, 1'b0, 0, 1'b0));
        directed.push_back(make_row(KIND_PIXEL, 130, 16'h7777, 1'b1, 16'h7777, 1'b0));
        // Animation on line 0: both ends of the entry, of the hold, and of the exit.
        directed.push_back(make_row(KIND_LINE_BEGIN, 0, 0, 1'b0, 0, 1'b0));
        directed.push_back(make_row(KIND_LINE_BEGIN, 0, ENTER_FRAMES - 1, 1'b0, 0, 1'b0));
        directed.push_back(make_row(KIND_LINE_BEGIN, 0, ENTER_FRAMES, 1'b0, 0, 1'b0));
        directed.push_back(make_row(KIND_LINE_BEGIN, 0, ENTER_FRAMES + HOLD_FRAMES,
            1'b0, 0, 1'b0));
        directed.push_back(make_row(KIND_LINE_BEGIN, 0, ENTER_FRAMES + HOLD_FRAMES + 1,
            1'b0, 0, 1'b0));
        directed.push_back(make_row(KIND_LINE_BEGIN, 0, 32'hFFFF_FFFF, 1'b0, 0, 1'b0));
        // A line past the last virtual line, then a restart back to the start offset.
        directed.push_back(make_row(KIND_LINE_BEGIN, 16'hFFFF, 0, 1'b0, 0, 1'b0));
        directed.push_back(make_row(KIND_RESTART, 0, 0, 1'b0, 0, 1'b0));
        directed.push_back(make_row(KIND_LINE_BEGIN, 94, 1, 1'b0, 0, 1'b0));
        directed.push_back(make_row(KIND_PIXEL, 5, 16'h2468, 1'b0, 0, 1'b0));

        foreach (directed[i])
            push_request(directed[i].req, directed[i].has_want, directed[i].want);
        drain();

        // Random phases, each under its own register setting and idling mix. The extremes
        // come first: a band covering lines up to the top, then one pushed out of reach.
        settings.push_back(make_setting(0, 0, 1023, 16'h0000, 16'hFFFF, 16'h8000, 1'b1,
            MIX_NONE));
        settings.push_back(make_setting(1023, 1023, 1023, 16'hFFFF, 16'h0001, 16'h7FFF, 1'b0,
            MIX_SENDER));
        settings.push_back(make_setting(12, 40, 200, $urandom_range(0, 65535),
            $urandom_range(0, 65535), $urandom_range(0, 65535), 1'b1, MIX_RECEIVER));
        settings.push_back(make_setting(300, 500, 1000, $urandom_range(0, 65535),
            $urandom_range(0, 65535), $urandom_range(0, 65535), 1'b0, MIX_BOTH));
        settings.push_back(make_setting(0, 0, 0, 0, 0, 0, 1'b0, MIX_NONE));
        settings.push_back(make_setting($urandom_range(0, 400), $urandom_range(0, 400), 1023,
            $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535),
            1'(($urandom_range(0, 1))), MIX_SENDER));

        foreach (settings[p]) begin
            apply_setting(settings[p]);
            if (p == 0) begin
                // Long receiver hold while requests keep coming, so the block backs up.
                random_traffic(40);
                hold_request = 1'b1;
                random_traffic(60);
            end else if (p == 2) begin
                // Sender pauses until every owed pixel has come back.
                random_traffic(40);
                drain();
                random_traffic(50);
            end else begin
                random_traffic(100);
            end
            drain();
        end

        repeat (2 * SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
